FILE: hdl/bcgs_pkg.sv
// ----------------------------------------------------------------------------
// bcgs_pkg
// Shared types, constants and helpers of the bouncing cell grid sequencer.
// ----------------------------------------------------------------------------
package bcgs_pkg;

	localparam int MaxSlotsDefault = 32;
	localparam int GridMaxDefault  = 16;

	localparam logic [1:0] HEAD_UP    = 2'd0;
	localparam logic [1:0] HEAD_RIGHT = 2'd1;
	localparam logic [1:0] HEAD_DOWN  = 2'd2;
	localparam logic [1:0] HEAD_LEFT  = 2'd3;

	localparam logic [2:0] OUT_STEP    = 3'd0;
	localparam logic [2:0] OUT_REMOVED = 3'd1;
	localparam logic [2:0] OUT_PLACED  = 3'd2;
	localparam logic [2:0] OUT_FULL    = 3'd3;
	localparam logic [2:0] OUT_OUTSIDE = 3'd4;

	localparam logic CFG_COLUMN_COUNT = 1'b0;
	localparam logic CFG_ROW_COUNT    = 1'b1;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	typedef struct packed {
		logic       command;
		logic [3:0] press_column;
		logic [3:0] press_row;
	} in_item_t;

	typedef struct packed {
		logic       top_hit;
		logic [3:0] top_column;
		logic       right_hit;
		logic [3:0] right_row;
		logic       bottom_hit;
		logic [3:0] bottom_column;
		logic       left_hit;
		logic [3:0] left_row;
		logic [2:0] press_outcome;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // start of a command: clear result and search flags
		logic move;       // move slot at index i
		logic count;      // compare slot i with slot j (j != i)
		logic turn;       // apply the turn count to slot i
		logic search;     // press search at slot i
		logic commit;     // finish press
	} dp_cmd_t;

	// Saturate a register value to 8..grid_max.
	function automatic logic [4:0] eff_size(input logic [4:0] v, input logic [4:0] gmax);
		logic [4:0] n;
		begin
			n = v;
			if (n < 5'd8) n = 5'd8;
			if (n > gmax) n = gmax;
			return n;
		end
	endfunction

endpackage

FILE: hdl/bouncing_cell_grid_sequencer.sv
// ----------------------------------------------------------------------------
// bouncing_cell_grid_sequencer
// Grid of bouncing cells stepped by clock requests and edited by presses.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake     | Payload
// in      | input     | in_valid/stall| command, press_column, press_row
// out     | output    | out_valid/stall| wall hits and press outcome
// cfg     | input     | valid/ready   | cfg_index, cfg_data
//
// A step request moves every slot, then compares each slot pair, one pair per
// cycle, to count collisions and turns each slot; a press request searches the
// slots for the pressed square and a free slot.
// One request is worked on at a time; the result register holds until taken
// and a new request is accepted while it waits. Reset is asynchronous and
// leaves every slot inactive, heading up, at square zero.
// ----------------------------------------------------------------------------
module bouncing_cell_grid_sequencer #(
	parameter int MAX_SLOTS = bcgs_pkg::MaxSlotsDefault,
	parameter int GRID_MAX  = bcgs_pkg::GridMaxDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bcgs_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bcgs_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [4:0]           cfg_data
);

	localparam int IW = $clog2(MAX_SLOTS + 1);

	logic [4:0] column_count_q, row_count_q;
	logic [4:0] cols, rows;
	logic [5:0] lim_sum;
	logic [IW-1:0] limit;
	bcgs_pkg::in_item_t item_q;
	bcgs_pkg::dp_cmd_t  cmd;
	bcgs_pkg::out_item_t result;
	logic idle, done, start, is_press;
	logic [IW-1:0] idx_i, idx_j;

	assign cols = bcgs_pkg::eff_size(column_count_q, 5'(GRID_MAX));
	assign rows = bcgs_pkg::eff_size(row_count_q, 5'(GRID_MAX));
	assign lim_sum = {1'b0, cols} + {1'b0, rows};
	assign limit = (lim_sum > 6'(MAX_SLOTS)) ? IW'(MAX_SLOTS) : IW'(lim_sum);

	assign in_stall  = !idle;
	assign start     = in_valid && idle;
	assign cfg_ready = 1'b1;

	// The incoming request picks the first state; later the held copy is used.
	assign is_press = start ? (in_data.command == bcgs_pkg::CMD_PRESS)
			: (item_q.command == bcgs_pkg::CMD_PRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 5'd8;
			row_count_q    <= 5'd8;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bcgs_pkg::CFG_COLUMN_COUNT) column_count_q <= cfg_data;
				else row_count_q <= cfg_data;
			end
			if (done) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) item_q <= in_data;
		if (done) out_data <= result;
	end

	bcgs_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
		.clk, .arst_n, .start, .is_press,
		.out_busy(out_valid && out_stall), .limit, .idle, .done, .cmd, .idx_i, .idx_j
	);

	bcgs_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk, .arst_n, .cmd, .idx_i, .idx_j, .item(item_q), .cols, .rows, .result
	);

endmodule

FILE: hdl/bcgs_ctrl.sv
// ----------------------------------------------------------------------------
// bcgs_ctrl
// Sequencer that walks slot indices for move, pairwise count, turn and press.
// ----------------------------------------------------------------------------
module bcgs_ctrl #(
	parameter int MAX_SLOTS = bcgs_pkg::MaxSlotsDefault,
	localparam int IW = $clog2(MAX_SLOTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  is_press,
	input  logic                  out_busy,
	input  logic [IW-1:0]         limit,
	output logic                  idle,
	output logic                  done,
	output bcgs_pkg::dp_cmd_t     cmd,
	output logic [IW-1:0]         idx_i,
	output logic [IW-1:0]         idx_j
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MOVE   = 3'd1;
	localparam logic [2:0] ST_COUNT  = 3'd2;
	localparam logic [2:0] ST_TURN   = 3'd3;
	localparam logic [2:0] ST_SEARCH = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]    state_q;
	logic [IW-1:0] i_q, j_q;

	assign idle  = (state_q == ST_IDLE);
	assign idx_i = i_q;
	assign idx_j = j_q;

	always_comb begin
		cmd = '0;
		done = 1'b0;
		case (state_q)
			ST_IDLE:   cmd.clear = start;
			ST_MOVE:   cmd.move = (i_q < limit);
			ST_COUNT:  cmd.count = (i_q < limit) && (j_q < limit) && (j_q != i_q);
			ST_TURN:   cmd.turn = (i_q < limit);
			ST_SEARCH: cmd.search = (i_q < limit);
			ST_DONE: begin
				cmd.commit = is_press && !out_busy;
				done = !out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					i_q <= '0;
					j_q <= '0;
					state_q <= is_press ? ST_SEARCH : ST_MOVE;
				end
				ST_MOVE: begin
					if (i_q >= limit) begin
						i_q <= '0;
						state_q <= ST_COUNT;
					end else i_q <= i_q + 1'b1;
				end
				ST_COUNT: begin
					if (j_q >= limit) begin
						j_q <= '0;
						state_q <= ST_TURN;
					end else j_q <= j_q + 1'b1;
				end
				ST_TURN: begin
					if (i_q >= limit) state_q <= ST_DONE;
					else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_COUNT;
					end
				end
				ST_SEARCH: begin
					if (i_q >= limit) state_q <= ST_DONE;
					else i_q <= i_q + 1'b1;
				end
				ST_DONE: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/bcgs_datapath.sv
// ----------------------------------------------------------------------------
// bcgs_datapath
// Slot store, move and bounce logic, collision counter and press search.
// ----------------------------------------------------------------------------
module bcgs_datapath #(
	parameter int MAX_SLOTS = bcgs_pkg::MaxSlotsDefault,
	localparam int IW = $clog2(MAX_SLOTS + 1),
	localparam int SW = $clog2(MAX_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcgs_pkg::dp_cmd_t     cmd,
	input  logic [IW-1:0]         idx_i,
	input  logic [IW-1:0]         idx_j,
	input  bcgs_pkg::in_item_t    item,
	input  logic [4:0]            cols,
	input  logic [4:0]            rows,
	output bcgs_pkg::out_item_t   result
);

	logic [MAX_SLOTS-1:0] active_q;
	logic [3:0]           col_q  [MAX_SLOTS];
	logic [3:0]           row_q  [MAX_SLOTS];
	logic [1:0]           head_q [MAX_SLOTS];

	logic [1:0]     turns_q;
	logic           hit_q [4];
	logic [3:0]     where_q [4];
	logic           found_q, free_q;
	logic [SW-1:0]  found_idx_q, free_idx_q;

	logic [SW-1:0] si, sj;
	logic [3:0]    c, r, nc, nr;
	logic [1:0]    h, nh;
	logic [4:0]    nx;
	logic [1:0]    wall;
	logic          bounce;
	logic          outside;

	assign si = idx_i[SW-1:0];
	assign sj = idx_j[SW-1:0];
	assign c  = col_q[si];
	assign r  = row_q[si];
	assign h  = head_q[si];
	assign outside = ({1'b0, item.press_column} >= cols) || ({1'b0, item.press_row} >= rows);

	// Next position and heading of slot i for a move.
	always_comb begin
		nc = c;
		nr = r;
		nh = h;
		nx = '0;
		bounce = 1'b0;
		wall = h;
		case (h)
			bcgs_pkg::HEAD_UP: begin
				if (r != 4'd0) nr = r - 4'd1;
				if (nr == 4'd0) begin
					nh = bcgs_pkg::HEAD_DOWN;
					bounce = 1'b1;
				end
			end
			bcgs_pkg::HEAD_RIGHT: begin
				nx = {1'b0, c} + 5'd1;
				if (nx >= cols - 5'd1) begin
					nc = 4'(cols - 5'd1);
					nh = bcgs_pkg::HEAD_LEFT;
					bounce = 1'b1;
				end else nc = nx[3:0];
			end
			bcgs_pkg::HEAD_DOWN: begin
				nx = {1'b0, r} + 5'd1;
				if (nx >= rows - 5'd1) begin
					nr = 4'(rows - 5'd1);
					nh = bcgs_pkg::HEAD_UP;
					bounce = 1'b1;
				end else nr = nx[3:0];
			end
			default: begin
				if (c != 4'd0) nc = c - 4'd1;
				if (nc == 4'd0) begin
					nh = bcgs_pkg::HEAD_RIGHT;
					bounce = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int k = 0; k < MAX_SLOTS; k++) begin
				col_q[k]  <= '0;
				row_q[k]  <= '0;
				head_q[k] <= bcgs_pkg::HEAD_UP;
			end
			for (int k = 0; k < 4; k++) begin
				hit_q[k]   <= 1'b0;
				where_q[k] <= '0;
			end
			turns_q <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			found_idx_q <= '0;
			free_idx_q  <= '0;
		end else begin
			if (cmd.clear) begin
				for (int k = 0; k < 4; k++) begin
					hit_q[k]   <= 1'b0;
					where_q[k] <= '0;
				end
				turns_q <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end
			if (cmd.move && active_q[si]) begin
				col_q[si]  <= nc;
				row_q[si]  <= nr;
				head_q[si] <= nh;
				if (bounce) begin
					hit_q[wall]   <= 1'b1;
					where_q[wall] <= (wall[0]) ? nr : nc;
				end
			end
			if (cmd.count && active_q[sj] && col_q[sj] == c && row_q[sj] == r)
				turns_q <= turns_q + 2'd1;
			if (cmd.turn) begin
				if (active_q[si]) head_q[si] <= h + turns_q;
				turns_q <= '0;
			end
			if (cmd.search) begin
				if (!found_q && active_q[si] && c == item.press_column && r == item.press_row) begin
					found_q <= 1'b1;
					found_idx_q <= si;
				end
				if (!free_q && !active_q[si]) begin
					free_q <= 1'b1;
					free_idx_q <= si;
				end
			end
			if (cmd.commit && !outside) begin
				if (found_q) active_q[found_idx_q] <= 1'b0;
				else if (free_q) begin
					active_q[free_idx_q] <= 1'b1;
					col_q[free_idx_q] <= item.press_column;
					row_q[free_idx_q] <= item.press_row;
				end
			end
		end
	end

	always_comb begin
		result = '0;
		if (item.command == bcgs_pkg::CMD_PRESS) begin
			if (outside) result.press_outcome = bcgs_pkg::OUT_OUTSIDE;
			else if (found_q) result.press_outcome = bcgs_pkg::OUT_REMOVED;
			else if (free_q) result.press_outcome = bcgs_pkg::OUT_PLACED;
			else result.press_outcome = bcgs_pkg::OUT_FULL;
		end else begin
			result.top_hit       = hit_q[0];
			result.top_column    = where_q[0];
			result.right_hit     = hit_q[1];
			result.right_row     = where_q[1];
			result.bottom_hit    = hit_q[2];
			result.bottom_column = where_q[2];
			result.left_hit      = hit_q[3];
			result.left_row      = where_q[3];
			result.press_outcome = bcgs_pkg::OUT_STEP;
		end
	end

endmodule

FILE: hdl/bcgs_checker.sv
// ----------------------------------------------------------------------------
// bcgs_checker
// Port-level checks of the bouncing cell grid sequencer.
// ----------------------------------------------------------------------------
module bcgs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input bcgs_pkg::out_item_t  out_data
);

	// A result does not become valid straight after a request is accepted.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid || $past(out_valid)) else $error("early result");

	// A press result carries no wall hits.
	a_press_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.press_outcome != bcgs_pkg::OUT_STEP |->
		!out_data.top_hit && !out_data.right_hit && !out_data.bottom_hit &&
		!out_data.left_hit) else $error("press with hits");

	// An unfired wall reports index zero.
	a_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.top_hit |-> out_data.top_column == 4'd0)
		else $error("stale top index");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");

endmodule

bind bouncing_cell_grid_sequencer bcgs_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

FILE: test/bouncing_cell_grid_sequencer_checker.sv
// ----------------------------------------------------------------------------
// bouncing_cell_grid_sequencer_checker
// Watches the request, result and register channels, keeps a model of the
// grid and compares every result with the predicted one, in order.
// ----------------------------------------------------------------------------
module bouncing_cell_grid_sequencer_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  bcgs_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  bcgs_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data,
	output int                  fail_count,
	output int                  pending
);

	localparam int NSLOT = 32;

	logic [4:0] grid_cols, grid_rows;
	logic       cell_on[NSLOT];
	logic [3:0] cell_col[NSLOT];
	logic [3:0] cell_row[NSLOT];
	logic [1:0] cell_head[NSLOT];
	bcgs_pkg::out_item_t expected_results[$];

	assign pending = expected_results.size();

	function automatic int clamp_size(input logic [4:0] v);
		int n;
		n = v;
		if (n < 8) n = 8;
		if (n > 16) n = 16;
		return n;
	endfunction

	function automatic int active_slots();
		int n;
		n = clamp_size(grid_cols) + clamp_size(grid_rows);
		return (n > NSLOT) ? NSLOT : n;
	endfunction

	function automatic bcgs_pkg::out_item_t advance_grid();
		bcgs_pkg::out_item_t res;
		int         cols, rows, n, c, r, turns;
		logic [1:0] spin[NSLOT];
		cols = clamp_size(grid_cols);
		rows = clamp_size(grid_rows);
		n = active_slots();
		res = '0;
		for (int i = 0; i < n; i++) begin
			if (!cell_on[i]) continue;
			c = cell_col[i];
			r = cell_row[i];
			case (cell_head[i])
				bcgs_pkg::HEAD_UP: begin
					if (r > 0) r--;
					if (r == 0) begin
						cell_head[i] = bcgs_pkg::HEAD_DOWN;
						res.top_hit = 1'b1;
						res.top_column = c[3:0];
					end
				end
				bcgs_pkg::HEAD_RIGHT: begin
					if (c + 1 >= cols - 1) begin
						c = cols - 1;
						cell_head[i] = bcgs_pkg::HEAD_LEFT;
						res.right_hit = 1'b1;
						res.right_row = r[3:0];
					end else c = c + 1;
				end
				bcgs_pkg::HEAD_DOWN: begin
					if (r + 1 >= rows - 1) begin
						r = rows - 1;
						cell_head[i] = bcgs_pkg::HEAD_UP;
						res.bottom_hit = 1'b1;
						res.bottom_column = c[3:0];
					end else r = r + 1;
				end
				default: begin
					if (c > 0) c--;
					if (c == 0) begin
						cell_head[i] = bcgs_pkg::HEAD_RIGHT;
						res.left_hit = 1'b1;
						res.left_row = r[3:0];
					end
				end
			endcase
			cell_col[i] = c[3:0];
			cell_row[i] = r[3:0];
		end
		for (int i = 0; i < n; i++) begin
			turns = 0;
			for (int j = 0; j < n; j++)
				if (j != i && cell_on[i] && cell_on[j] && cell_col[j] == cell_col[i]
						&& cell_row[j] == cell_row[i])
					turns++;
			spin[i] = turns[1:0];
		end
		for (int i = 0; i < n; i++)
			if (cell_on[i]) cell_head[i] = cell_head[i] + spin[i];
		res.press_outcome = bcgs_pkg::OUT_STEP;
		return res;
	endfunction

	function automatic logic [2:0] toggle_cell(input logic [3:0] c, input logic [3:0] r);
		int n;
		n = active_slots();
		if (c >= clamp_size(grid_cols) || r >= clamp_size(grid_rows))
			return bcgs_pkg::OUT_OUTSIDE;
		for (int i = 0; i < n; i++)
			if (cell_on[i] && cell_col[i] == c && cell_row[i] == r) begin
				cell_on[i] = 1'b0;
				return bcgs_pkg::OUT_REMOVED;
			end
		for (int i = 0; i < n; i++)
			if (!cell_on[i]) begin
				cell_on[i] = 1'b1;
				cell_col[i] = c;
				cell_row[i] = r;
				return bcgs_pkg::OUT_PLACED;
			end
		return bcgs_pkg::OUT_FULL;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bcgs_pkg::out_item_t exp_item;
		if (!arst_n) begin
			grid_cols <= 5'd8;
			grid_rows <= 5'd8;
			fail_count <= 0;
			expected_results.delete();
			for (int i = 0; i < NSLOT; i++) begin
				cell_on[i] = 1'b0;
				cell_col[i] = '0;
				cell_row[i] = '0;
				cell_head[i] = bcgs_pkg::HEAD_UP;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bcgs_pkg::CFG_COLUMN_COUNT) grid_cols <= cfg_data;
				else grid_rows <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_item = expected_results.pop_front();
					if (exp_item !== out_data) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", exp_item, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				exp_item = '0;
				if (in_data.command == bcgs_pkg::CMD_STEP) exp_item = advance_grid();
				else exp_item.press_outcome = toggle_cell(in_data.press_column,
						in_data.press_row);
				expected_results.push_back(exp_item);
			end
		end
	end

endmodule

FILE: test/bouncing_cell_grid_sequencer_test.sv
// ----------------------------------------------------------------------------
// bouncing_cell_grid_sequencer_test
// Drives step and press requests through several grid sizes with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module bouncing_cell_grid_sequencer_test;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	bcgs_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	bcgs_pkg::out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = bcgs_pkg::CFG_COLUMN_COUNT;
	logic [4:0] cfg_data = '0;
	int        fail_count, pending;
	int        send_idle = 0, recv_idle = 0;
	longint    cycle = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bouncing_cell_grid_sequencer u_top (.*);

	bouncing_cell_grid_sequencer_checker u_check (.*);

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 64'd3_000_000) begin
			$display("bouncing_cell_grid_sequencer_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	// Valid drops only while the sender idles, so back-to-back requests keep it high.
	task automatic send_request(input logic cmd, input logic [3:0] c, input logic [3:0] r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, press_column: c, press_row: r};
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every request has its result taken before writing.
	task automatic write_size(input logic idx, input logic [4:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly presses inside the grid so that cells pile up and collide.
	task automatic random_phase(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 45)
				send_request(bcgs_pkg::CMD_STEP, 4'($urandom), 4'($urandom));
			else if ($urandom_range(9) == 0)
				send_request(bcgs_pkg::CMD_PRESS, 4'($urandom), 4'($urandom));
			else
				send_request(bcgs_pkg::CMD_PRESS, 4'($urandom_range(7)),
						4'($urandom_range(7)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Corners, out-of-grid presses, and a cell removed again.
		send_request(bcgs_pkg::CMD_PRESS, 4'd0, 4'd0);
		send_request(bcgs_pkg::CMD_PRESS, 4'd7, 4'd7);
		send_request(bcgs_pkg::CMD_PRESS, 4'd15, 4'd15);
		send_request(bcgs_pkg::CMD_PRESS, 4'd8, 4'd0);
		send_request(bcgs_pkg::CMD_PRESS, 4'd7, 4'd0);
		send_request(bcgs_pkg::CMD_PRESS, 4'd0, 4'd7);
		send_request(bcgs_pkg::CMD_PRESS, 4'd3, 4'd3);
		send_request(bcgs_pkg::CMD_PRESS, 4'd3, 4'd3);
		send_request(bcgs_pkg::CMD_PRESS, 4'd3, 4'd3);
		repeat (8) send_request(bcgs_pkg::CMD_STEP, 4'd15, 4'd15);
		// Press a block of squares so that the free slots run out.
		for (int i = 0; i < 17; i++)
			send_request(bcgs_pkg::CMD_PRESS, {1'b0, i[2:0]}, 4'(i[5:3]) + 4'd1);
		send_idle = 20;
		recv_idle = 56;
		random_phase(150);
		write_size(bcgs_pkg::CFG_COLUMN_COUNT, 5'd16);
		write_size(bcgs_pkg::CFG_ROW_COUNT, 5'd16);
		send_idle = 56;
		recv_idle = 20;
		for (int i = 0; i < 20; i++)
			send_request(bcgs_pkg::CMD_PRESS, 4'($urandom), 4'($urandom));
		random_phase(150);
		write_size(bcgs_pkg::CFG_COLUMN_COUNT, 5'd3);
		write_size(bcgs_pkg::CFG_ROW_COUNT, 5'd31);
		send_idle = 0;
		recv_idle = 0;
		random_phase(110);
		write_size(bcgs_pkg::CFG_COLUMN_COUNT, 5'd12);
		write_size(bcgs_pkg::CFG_ROW_COUNT, 5'd9);
		random_phase(110);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0) $display("bouncing_cell_grid_sequencer_test OK");
		else $display("bouncing_cell_grid_sequencer_test NOT OK");
		$finish;
	end

endmodule

FILE: files.f
hdl/bcgs_pkg.sv
hdl/bcgs_ctrl.sv
hdl/bcgs_datapath.sv
hdl/bouncing_cell_grid_sequencer.sv
hdl/bcgs_checker.sv
test/bouncing_cell_grid_sequencer_checker.sv
test/bouncing_cell_grid_sequencer_test.sv
